[sv/osr_pkg.sv]
// ----------------------------------------------------------------------------
// osr_pkg
// Shared types and constants for the obstacle steering ramp block.
// ----------------------------------------------------------------------------
package osr_pkg;

    // field widths
    localparam int unsigned RANGE_W = 13;
    localparam int unsigned STEP_W  = 6;
    localparam int unsigned CEIL_W  = 8;
    localparam int unsigned STEER_W = 10;
    localparam int unsigned TIER_W  = 2;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DANGER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAREFUL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UP_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING   = 3'd6;

    // reset values (tenths of cm; steering units)
    localparam logic [RANGE_W-1:0] MIN_VALID_RST = 13'd20;
    localparam logic [RANGE_W-1:0] DANGER_RST    = 13'd100;
    localparam logic [RANGE_W-1:0] CAREFUL_RST   = 13'd300;
    localparam logic [RANGE_W-1:0] WARNING_RST   = 13'd500;
    localparam logic [STEP_W-1:0]  UP_STEP_RST   = 6'd5;
    localparam logic [STEP_W-1:0]  DOWN_STEP_RST = 6'd10;
    localparam logic [CEIL_W-1:0]  CEILING_RST   = 8'd20;

    // hazard tiers
    localparam logic [TIER_W-1:0] TIER_NONE    = 2'd0;
    localparam logic [TIER_W-1:0] TIER_DANGER  = 2'd1;
    localparam logic [TIER_W-1:0] TIER_CAREFUL = 2'd2;
    localparam logic [TIER_W-1:0] TIER_WARNING = 2'd3;

    // avoidance modes
    localparam logic [MODE_W-1:0] MODE_IDLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TURNING  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STOPPING = 2'd3;

    // distance thresholds handed to the classifier
    typedef struct packed {
        logic [RANGE_W-1:0] min_valid;
        logic [RANGE_W-1:0] danger;
        logic [RANGE_W-1:0] careful;
        logic [RANGE_W-1:0] warning;
    } thresh_t;

endpackage

[sv/osr_classify.sv]
// ----------------------------------------------------------------------------
// osr_classify
// Sorts one range reading into a hazard tier against the four thresholds.
// ----------------------------------------------------------------------------
module osr_classify (
    input  osr_pkg::thresh_t                    thresh,
    input  logic [osr_pkg::RANGE_W-1:0]         range_reading,
    output logic [osr_pkg::TIER_W-1:0]          hazard_tier
);
    import osr_pkg::*;

    // first matching test wins, even with thresholds out of order
    always_comb begin
        if (range_reading < thresh.min_valid) begin
            hazard_tier = TIER_NONE;
        end else if (range_reading <= thresh.danger) begin
            hazard_tier = TIER_DANGER;
        end else if (range_reading <= thresh.careful) begin
            hazard_tier = TIER_CAREFUL;
        end else if (range_reading < thresh.warning) begin
            hazard_tier = TIER_WARNING;
        end else begin
            hazard_tier = TIER_NONE;
        end
    end

endmodule

[sv/obstacle_steer_ramp_fsm_unit.sv]
// ----------------------------------------------------------------------------
// obstacle_steer_ramp_fsm_unit
// Classifies each range reading into a hazard tier and steps a four-mode
// machine that ramps a signed steering target up, holds, and ramps it down.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  s_       | in        | s_range_reading[12:0]
//  m_       | out       | m_steer_target[9:0] signed, m_hazard_tier, m_avoid_mode
//  cfg_     | in        | cfg_index[2:0], cfg_data[12:0]
//
//  One item per cycle unless m_ stalls; each result shows in the next cycle.
//  Classification and the mode/target update are one combinational pass that
//  loads the result register; s_ready is high whenever that register is empty
//  or being drained, so a stall on m_ stalls s_ only when a result is held.
//  Reset restores the register defaults, mode idle and target zero.
//  cfg_ready is always high; writes to index 7 are ignored.
// ----------------------------------------------------------------------------
module obstacle_steer_ramp_fsm_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [osr_pkg::RANGE_W-1:0]         s_range_reading,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [osr_pkg::STEER_W-1:0]  m_steer_target,
    output logic [osr_pkg::TIER_W-1:0]          m_hazard_tier,
    output logic [osr_pkg::MODE_W-1:0]          m_avoid_mode,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [osr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [osr_pkg::RANGE_W-1:0]         cfg_data
);
    import osr_pkg::*;

    thresh_t                     thresh_reg;
    logic [STEP_W-1:0]           up_step_reg;
    logic [STEP_W-1:0]           down_step_reg;
    logic [CEIL_W-1:0]           ceiling_reg;

    logic [MODE_W-1:0]           mode_reg, mode_next;
    logic signed [STEER_W-1:0]   steer_reg, steer_next;

    logic                        m_valid_reg;
    logic signed [STEER_W-1:0]   m_steer_reg;
    logic [TIER_W-1:0]           m_tier_reg;
    logic [MODE_W-1:0]           m_mode_reg;

    logic [TIER_W-1:0]           tier;
    logic                        s_accept;
    logic                        hazard;
    logic                        at_ceiling;
    logic                        at_floor;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg.min_valid <= MIN_VALID_RST;
            thresh_reg.danger    <= DANGER_RST;
            thresh_reg.careful   <= CAREFUL_RST;
            thresh_reg.warning   <= WARNING_RST;
            up_step_reg          <= UP_STEP_RST;
            down_step_reg        <= DOWN_STEP_RST;
            ceiling_reg          <= CEILING_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MIN_VALID: thresh_reg.min_valid <= cfg_data;
                REG_DANGER:    thresh_reg.danger    <= cfg_data;
                REG_CAREFUL:   thresh_reg.careful   <= cfg_data;
                REG_WARNING:   thresh_reg.warning   <= cfg_data;
                REG_UP_STEP:   up_step_reg          <= cfg_data[STEP_W-1:0];
                REG_DOWN_STEP: down_step_reg        <= cfg_data[STEP_W-1:0];
                REG_CEILING:   ceiling_reg          <= cfg_data[CEIL_W-1:0];
                default: ;
            endcase
        end
    end

    // tier of the incoming reading
    osr_classify u_classify (
        .thresh        (thresh_reg),
        .range_reading (s_range_reading),
        .hazard_tier   (tier)
    );

    assign hazard     = (tier != TIER_NONE);
    assign at_ceiling = (steer_reg >= $signed({2'b00, ceiling_reg}));
    assign at_floor   = (steer_reg <= $signed({STEER_W{1'b0}}));

    // mode and target update
    always_comb begin
        mode_next  = mode_reg;
        steer_next = steer_reg;
        case (mode_reg)
            MODE_IDLE: begin
                if (hazard) begin
                    steer_next = '0;
                    mode_next  = MODE_TURNING;
                end
            end
            MODE_TURNING: begin
                if (!hazard || at_ceiling) begin
                    mode_next = MODE_END;
                end else begin
                    steer_next = steer_reg + $signed({4'b0000, up_step_reg});
                end
            end
            MODE_END: begin
                mode_next = MODE_STOPPING;
            end
            MODE_STOPPING: begin
                if (!hazard || at_floor) begin
                    steer_next = '0;
                    mode_next  = MODE_IDLE;
                end else begin
                    steer_next = steer_reg - $signed({4'b0000, down_step_reg});
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            steer_reg <= '0;
        end else if (s_accept) begin
            mode_reg  <= mode_next;
            steer_reg <= steer_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_steer_reg <= steer_next;
            m_tier_reg  <= tier;
            m_mode_reg  <= mode_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_steer_target = m_steer_reg;
    assign m_hazard_tier  = m_tier_reg;
    assign m_avoid_mode   = m_mode_reg;

endmodule
